[rtl/arst_pkg.sv]
`default_nettype none
package arst_pkg;

    // Default sizing
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int TYPE_BITS_DEF   = 4;

    // Register reset values
    localparam logic [31:0] FLOOR_RESET   = 32'h0080_0000;
    localparam logic [31:0] CEILING_RESET = 32'h8000_0000;

    // Configuration register indexes
    localparam logic CFG_ALLOC_FLOOR  = 1'b0;
    localparam logic CFG_USER_CEILING = 1'b1;

    // Operation codes
    localparam logic OP_CREATE = 1'b0;
    localparam logic OP_FREE   = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_ZERO  = 2'd2,
        STAT_NOFIT = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PRE,
        S_SCAN,
        S_DEC,
        S_FCUTE,
        S_SHIFT,
        S_WR1,
        S_WR2,
        S_MPRE,
        S_MERGE,
        S_DONE
    } t_state;

    // Which step a table edit belongs to
    typedef enum logic [1:0] {
        PH_CREATE,
        PH_CUT_A,
        PH_CUT_E
    } t_phase;

    // Channel payloads
    typedef struct packed {
        logic        op;
        logic [31:0] address;
        logic [31:0] size;
        logic [3:0]  seg_type;
        logic        fixed;
    } t_req_item;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
    } t_rsp_item;

    typedef struct packed {
        logic        index;
        logic [31:0] wdata;
    } t_cfg_item;

endpackage
`default_nettype wire

[rtl/arst_chan_if.sv]
`default_nettype none
interface arst_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/arst_table_ram.sv]
`default_nettype none
module arst_table_ram #(
    parameter int DEPTH = arst_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = 32 + arst_pkg::TYPE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

[rtl/address_range_segment_table_top.sv]
`default_nettype none
// Channel  | Dir | Payload                                   | Accepted when
// i_req    | in  | op, address, size, seg_type, fixed        | valid & ready
// o_rsp    | out | result_addr, status                       | valid & ready
// i_cfg    | in  | index (0 alloc_floor, 1 user_ceiling), wdata | valid & ready
//
// One item at a time. A create runs a scan of the table plus, when entries
// must move, a shift pass; a free runs a scan, up to two shift passes and a
// merge pass. Each pass walks the table through the single read port of the
// boundary memory.
// After reset the S_INIT state writes the initial free entry before i_req is ready.
// A finished result waits in the output register while the next item runs.
module address_range_segment_table_top #(
    parameter int TABLE_DEPTH = arst_pkg::TABLE_DEPTH_DEF,
    parameter int TYPE_BITS   = arst_pkg::TYPE_BITS_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    arst_chan_if.sink   i_req,
    arst_chan_if.source o_rsp,
    arst_chan_if.sink   i_cfg
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TB = TYPE_BITS;
    localparam int EW = 32 + TB;
    localparam logic [TB-1:0] T_FREE = '0;
    localparam logic [CW:0]   DEPTH_C = (CW+1)'(TABLE_DEPTH);

    arst_pkg::t_state  r_state, n_state;
    arst_pkg::t_phase  r_ph;
    arst_pkg::t_req_item r_req;

    logic [CW-1:0] r_count;
    logic [31:0]   r_floor, r_ceil;

    // scan
    logic [CW-1:0] r_j;
    logic [31:0]   r_ps;
    logic [TB-1:0] r_pt;
    logic          r_found, r_fe;
    logic [IW-1:0] r_idx, r_ie;
    logic [31:0]   r_s, r_a, r_se;
    logic [32:0]   r_e;
    logic [TB-1:0] r_ft, r_te;

    // edit
    logic          r_adj;
    logic [CW-1:0] r_lo, r_hi;
    logic [IW-1:0] r_k, r_at, r_wa;
    logic [1:0]    r_n;
    logic          r_iss, r_wv;
    logic [IW-1:0] r_w1a, r_w2a;
    logic [EW-1:0] r_w1d, r_w2d;
    logic          r_w2v;

    // merge
    logic [CW-1:0] r_t, r_sc;
    logic [TB-1:0] r_lt;

    // result
    logic [31:0] r_raddr, r_oaddr;
    arst_pkg::t_status r_rstat, r_ostat;
    logic r_ov;

    // memory port
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;
    logic          we;
    logic [31:0]   rd_start;
    logic [TB-1:0] rd_type;

    assign rd_start = rd_data[EW-1:TB];
    assign rd_type  = rd_data[TB-1:0];

    arst_table_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(EW)) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // handshakes
    logic req_acc, rsp_free;
    assign i_req.ready = (r_state == arst_pkg::S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = '{result_addr: r_oaddr, status: r_ostat};
    assign rsp_free    = !r_ov || o_rsp.ready;

    // derived request values
    logic [32:0]   endv, hint, hint_end, szx;
    logic [TB-1:0] ty;
    assign szx      = {1'b0, r_req.size};
    assign endv     = {1'b0, r_req.address} + szx;
    assign hint     = {1'b0, (r_req.address != 32'd0) ? r_req.address : r_floor};
    assign hint_end = hint + szx;
    assign ty       = TB'(r_req.seg_type);

    // early checks on a new item
    logic              early_done;
    arst_pkg::t_status early_stat;
    always_comb begin
        early_done = 1'b1;
        early_stat = arst_pkg::STAT_OK;
        if (i_req.data.op == arst_pkg::OP_CREATE) begin
            if (({1'b0, r_count} + (CW+1)'(3)) >= DEPTH_C) begin
                early_stat = arst_pkg::STAT_FULL;
            end else if (i_req.data.size == 32'd0) begin
                early_stat = arst_pkg::STAT_ZERO;
            end else begin
                early_done = 1'b0;
            end
        end else begin
            if (i_req.data.address == 32'd0) begin
                early_stat = arst_pkg::STAT_OK;
            end else if (i_req.data.size == 32'd0) begin
                early_stat = arst_pkg::STAT_ZERO;
            end else if (({1'b0, r_count} + (CW+1)'(2)) > DEPTH_C) begin
                early_stat = arst_pkg::STAT_FULL;
            end else begin
                early_done = 1'b0;
            end
        end
    end

    // scan compare on entry r_j-1
    logic [32:0] sc_s, sc_e;
    logic        hit_a, hit_e, hit_ff, ff_at_hint, use_loc;
    assign sc_s       = {1'b0, r_ps};
    assign sc_e       = (r_j < r_count) ? {1'b0, rd_start} : {1'b0, r_ceil};
    assign use_loc    = (r_req.op == arst_pkg::OP_FREE) || r_req.fixed;
    assign hit_a      = (sc_s <= {1'b0, r_req.address}) && ({1'b0, r_req.address} < sc_e);
    assign hit_e      = (sc_s <= endv) && (endv < sc_e);
    assign ff_at_hint = (sc_s <= hint) && (hint_end <= sc_e);
    assign hit_ff     = (r_pt == T_FREE) && (sc_e > sc_s) &&
                        (ff_at_hint || ((sc_s >= hint) && (szx <= sc_e - sc_s)));

    // edit decisions
    logic              dec_fail, dec_shift, dec_w2v, dec_hi_set;
    logic [CW-1:0]     dec_at, dec_hi;
    logic [1:0]        dec_n;
    logic [IW-1:0]     dec_w1a, dec_w2a;
    logic [EW-1:0]     dec_w1d, dec_w2d;
    logic [32:0]       b_end;
    logic [CW-1:0]     ie_n, idx_c;
    logic [31:0]       se_n;
    logic [TB-1:0]     te_n;
    assign b_end = {1'b0, r_a} + szx;
    assign idx_c = CW'(r_idx);
    assign ie_n  = CW'(r_ie) + CW'(r_adj);
    assign se_n  = (r_adj && (r_ie == r_idx)) ? r_req.address : r_se;
    assign te_n  = (r_adj && (r_ie == r_idx)) ? r_ft : r_te;

    always_comb begin
        dec_fail   = 1'b0;
        dec_shift  = 1'b0;
        dec_at     = '0;
        dec_n      = 2'd1;
        dec_w1a    = '0;
        dec_w1d    = '0;
        dec_w2a    = '0;
        dec_w2d    = '0;
        dec_w2v    = 1'b0;
        dec_hi_set = 1'b0;
        dec_hi     = r_count;
        if (r_state == arst_pkg::S_FCUTE) begin
            // split at the end of a freed range
            if (endv[31:0] == r_ceil && !endv[32]) begin
                dec_hi_set = 1'b1;
            end else if (se_n == endv[31:0]) begin
                dec_hi_set = 1'b1;
                dec_hi     = ie_n;
            end else begin
                dec_shift = 1'b1;
                dec_at    = ie_n + CW'(1);
                dec_w1a   = IW'(ie_n + CW'(1));
                dec_w1d   = {endv[31:0], te_n};
                dec_hi    = ie_n + CW'(1);
            end
        end else if (r_req.op == arst_pkg::OP_CREATE) begin
            if (!r_found || (r_req.fixed &&
                    ((r_ft != T_FREE) || (endv > r_e)))) begin
                dec_fail = 1'b1;
            end else if ((r_s == r_a) && (b_end == r_e)) begin
                dec_w1a = r_idx;
                dec_w1d = {r_s, ty};
            end else if ((r_s < r_a) && (b_end < r_e)) begin
                dec_shift = 1'b1;
                dec_at    = idx_c + CW'(1);
                dec_n     = 2'd2;
                dec_w1a   = IW'(idx_c + CW'(1));
                dec_w1d   = {r_a, ty};
                dec_w2v   = 1'b1;
                dec_w2a   = IW'(idx_c + CW'(2));
                dec_w2d   = {b_end[31:0], T_FREE};
            end else if (r_s == r_a) begin
                dec_shift = 1'b1;
                dec_at    = idx_c + CW'(1);
                dec_w1a   = r_idx;
                dec_w1d   = {r_s, ty};
                dec_w2v   = 1'b1;
                dec_w2a   = IW'(idx_c + CW'(1));
                dec_w2d   = {b_end[31:0], T_FREE};
            end else begin
                dec_shift = 1'b1;
                dec_at    = idx_c + CW'(1);
                dec_w1a   = IW'(idx_c + CW'(1));
                dec_w1d   = {r_a, ty};
            end
        end else begin
            // split at the start of a freed range
            if (!r_found || (endv > {1'b0, r_ceil}) ||
                    ((endv < {1'b0, r_ceil}) && !r_fe)) begin
                dec_fail = 1'b1;
            end else if (r_s != r_req.address) begin
                dec_shift = 1'b1;
                dec_at    = idx_c + CW'(1);
                dec_w1a   = IW'(idx_c + CW'(1));
                dec_w1d   = {r_req.address, r_ft};
            end
        end
    end

    // merge step on entry r_t
    logic [TB-1:0] m_ty;
    logic          m_skip, m_last;
    assign m_ty   = ((r_t >= r_lo) && (r_t < r_hi)) ? T_FREE : rd_type;
    assign m_skip = (r_sc != '0) && (r_lt == T_FREE) && (m_ty == T_FREE);
    assign m_last = (r_t == r_count - CW'(1));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arst_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory port
    always_comb begin
        n_state = r_state;
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (r_state)
            arst_pkg::S_INIT: begin
                we      = 1'b1;
                wr_data = {32'd0, T_FREE};
                n_state = arst_pkg::S_IDLE;
            end
            arst_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_state = early_done ? arst_pkg::S_DONE : arst_pkg::S_PRE;
                end
            end
            arst_pkg::S_PRE: begin
                n_state = arst_pkg::S_SCAN;
            end
            arst_pkg::S_SCAN: begin
                rd_addr = IW'(r_j + CW'(1));
                if (r_j == r_count) begin
                    n_state = arst_pkg::S_DEC;
                end
            end
            arst_pkg::S_DEC: begin
                if (dec_fail) begin
                    n_state = arst_pkg::S_DONE;
                end else if (dec_shift) begin
                    n_state = arst_pkg::S_SHIFT;
                end else if (r_req.op == arst_pkg::OP_CREATE) begin
                    n_state = arst_pkg::S_WR1;
                end else begin
                    n_state = arst_pkg::S_FCUTE;
                end
            end
            arst_pkg::S_FCUTE: begin
                n_state = dec_shift ? arst_pkg::S_SHIFT : arst_pkg::S_MPRE;
            end
            arst_pkg::S_SHIFT: begin
                rd_addr = r_k;
                we      = r_wv;
                wr_addr = r_wa;
                wr_data = rd_data;
                if (!r_iss && !r_wv) begin
                    n_state = arst_pkg::S_WR1;
                end
            end
            arst_pkg::S_WR1, arst_pkg::S_WR2: begin
                we      = 1'b1;
                wr_addr = (r_state == arst_pkg::S_WR1) ? r_w1a : r_w2a;
                wr_data = (r_state == arst_pkg::S_WR1) ? r_w1d : r_w2d;
                if (r_state == arst_pkg::S_WR1 && r_w2v) begin
                    n_state = arst_pkg::S_WR2;
                end else begin
                    case (r_ph)
                        arst_pkg::PH_CREATE: n_state = arst_pkg::S_DONE;
                        arst_pkg::PH_CUT_A:  n_state = arst_pkg::S_FCUTE;
                        default:             n_state = arst_pkg::S_MPRE;
                    endcase
                end
            end
            arst_pkg::S_MPRE: begin
                n_state = arst_pkg::S_MERGE;
            end
            arst_pkg::S_MERGE: begin
                rd_addr = IW'(r_t + CW'(1));
                we      = !m_skip;
                wr_addr = IW'(r_sc);
                wr_data = {rd_start, m_ty};
                if (m_last) begin
                    n_state = arst_pkg::S_DONE;
                end
            end
            arst_pkg::S_DONE: begin
                if (rsp_free) begin
                    n_state = arst_pkg::S_IDLE;
                end
            end
            default: n_state = arst_pkg::S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= arst_pkg::FLOOR_RESET;
            r_ceil  <= arst_pkg::CEILING_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.index == arst_pkg::CFG_ALLOC_FLOOR) begin
                r_floor <= i_cfg.data.wdata;
            end else begin
                r_ceil <= i_cfg.data.wdata;
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
        end else if ((r_state == arst_pkg::S_DEC || r_state == arst_pkg::S_FCUTE) &&
                     dec_shift && !dec_fail) begin
            r_count <= r_count + CW'(dec_n);
        end else if (r_state == arst_pkg::S_MERGE && m_last) begin
            r_count <= r_sc + CW'(!m_skip);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == arst_pkg::S_DONE && rsp_free) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == arst_pkg::S_DONE && rsp_free) begin
            r_oaddr <= r_raddr;
            r_ostat <= r_rstat;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            arst_pkg::S_IDLE: begin
                r_req   <= i_req.data;
                r_rstat <= early_stat;
                r_raddr <= 32'd0;
                r_ph    <= (i_req.data.op == arst_pkg::OP_CREATE) ?
                           arst_pkg::PH_CREATE : arst_pkg::PH_CUT_A;
                r_j     <= '0;
                r_found <= 1'b0;
                r_fe    <= 1'b0;
                r_adj   <= 1'b0;
            end
            arst_pkg::S_SCAN: begin
                r_ps <= rd_start;
                r_pt <= rd_type;
                r_j  <= r_j + CW'(1);
                if (r_j != '0) begin
                    if (!r_found && ((use_loc && hit_a) || (!use_loc && hit_ff))) begin
                        r_found <= 1'b1;
                        r_idx   <= IW'(r_j - CW'(1));
                        r_s     <= r_ps;
                        r_e     <= sc_e;
                        r_ft    <= r_pt;
                        r_a     <= use_loc ? r_req.address :
                                   (ff_at_hint ? hint[31:0] : r_ps);
                    end
                    if (!r_fe && hit_e) begin
                        r_fe <= 1'b1;
                        r_ie <= IW'(r_j - CW'(1));
                        r_se <= r_ps;
                        r_te <= r_pt;
                    end
                end
            end
            arst_pkg::S_DEC, arst_pkg::S_FCUTE: begin
                r_w1a <= dec_w1a;
                r_w1d <= dec_w1d;
                r_w2a <= dec_w2a;
                r_w2d <= dec_w2d;
                r_w2v <= dec_w2v;
                r_n   <= dec_n;
                r_at  <= IW'(dec_at);
                r_k   <= IW'(r_count - CW'(1));
                r_iss <= (dec_at != r_count);
                r_wv  <= 1'b0;
                if (r_state == arst_pkg::S_DEC) begin
                    if (dec_fail) begin
                        r_rstat <= arst_pkg::STAT_NOFIT;
                    end else if (r_req.op == arst_pkg::OP_CREATE) begin
                        r_raddr <= r_a;
                    end else begin
                        r_adj <= dec_shift;
                        r_lo  <= dec_shift ? idx_c + CW'(1) : idx_c;
                        r_ph  <= arst_pkg::PH_CUT_A;
                    end
                end else begin
                    r_hi <= dec_hi_set ? dec_hi : dec_hi;
                    r_ph <= arst_pkg::PH_CUT_E;
                end
            end
            arst_pkg::S_SHIFT: begin
                if (r_iss) begin
                    r_wa <= IW'(r_k + IW'(r_n));
                    r_wv <= 1'b1;
                    if (r_k == r_at) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_k <= r_k - IW'(1);
                    end
                end else begin
                    r_wv <= 1'b0;
                end
            end
            arst_pkg::S_MPRE: begin
                r_t  <= '0;
                r_sc <= '0;
                r_lt <= T_FREE;
            end
            arst_pkg::S_MERGE: begin
                r_t <= r_t + CW'(1);
                if (!m_skip) begin
                    r_sc <= r_sc + CW'(1);
                    r_lt <= m_ty;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire
